[design/vsis_pkg.sv]
`default_nettype none

package vsis_pkg;

  localparam int unsigned VERTICAL_REPEAT_DEF = 2;
  localparam int unsigned QUEUE_DEPTH_DEF     = 8;
  localparam int unsigned MAX_SAMPLES_DEF     = 4;

  localparam int unsigned LATE_MAX = 255;

  typedef enum logic [1:0] {
    LS_ACTIVE = 2'd0,
    LS_SYNC   = 2'd1,
    LS_FRONT  = 2'd2,
    LS_BACK   = 2'd3
  } line_state_e;

  typedef enum logic [2:0] {
    LK_BLANK       = 3'd0,
    LK_ACTIVE      = 3'd1,
    LK_ERROR       = 3'd2,
    LK_VBLANK_SYNC = 3'd3,
    LK_VBLANK      = 3'd4
  } line_kind_e;

  typedef enum logic [2:0] {
    PK_NULL       = 3'd0,
    PK_VIDEO_INFO = 3'd1,
    PK_AUDIO_INFO = 3'd2,
    PK_CLOCK_REGEN = 3'd3,
    PK_AUDIO      = 3'd4
  } packet_kind_e;

  typedef enum logic [3:0] {
    REG_BLANK_TOP       = 4'd0,
    REG_BLANK_BOTTOM    = 4'd1,
    REG_ACTIVE_LINES    = 4'd2,
    REG_SCANLINE_EFFECT = 4'd3,
    REG_ISLAND_ENABLE   = 4'd4,
    REG_AUDIO_ENABLE    = 4'd5,
    REG_AUDIO_STEP      = 4'd6,
    REG_VSYNC_POLARITY  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [10:0] blank_top;
    logic [10:0] blank_bottom;
    logic [10:0] active_lines;
    logic        scanline_effect;
    logic        island_enable;
    logic        audio_enable;
    logic [23:0] audio_step;
    logic        vsync_polarity;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  late_count;
    logic        frame_parity;
    logic        release_newer;
    logic        release_older;
    logic [31:0] sample_accum;
  } sched_state_t;

  typedef struct packed {
    line_state_e line_state;
    logic [10:0] line_index;
    logic [3:0]  ready_lines;
    logic [9:0]  audio_available;
  } item_t;

  typedef struct packed {
    line_kind_e   line_kind;
    logic         show_from_queue;
    logic         pop_shown;
    logic [3:0]   dropped_lines;
    logic         return_shown;
    logic         callback_fire;
    logic [10:0]  callback_line;
    packet_kind_e packet_kind;
    logic [2:0]   sample_count;
    logic         vsync_level;
  } result_t;

endpackage

`default_nettype wire

[design/vsis_sched.sv]
`default_nettype none

module vsis_sched
  import vsis_pkg::*;
#(
  parameter int unsigned VERTICAL_REPEAT = VERTICAL_REPEAT_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_SAMPLES     = MAX_SAMPLES_DEF
) (
  input  cfg_t         cfg_i,
  input  sched_state_t state_i,
  input  item_t        item_i,
  output result_t      result_o,
  output sched_state_t state_o
);

  // Divide the line index by the repeat count with a reciprocal multiply.
  localparam int unsigned DivShift = 22;
  localparam longint unsigned DivMult =
    ((64'd1 << DivShift) + VERTICAL_REPEAT - 1) / VERTICAL_REPEAT;

  logic [35:0] prod0;
  logic [35:0] prod1;
  logic [10:0] quot0;
  logic [11:0] quot1;
  logic        last_rep;

  logic [3:0]  ready_c;
  logic [3:0]  dropped;
  logic [3:0]  ready_left;
  logic [7:0]  late_after;
  logic        bottom_blank;
  logic        blank;
  logic        have;

  logic [31:0] acc_sum;
  logic [15:0] acc_int;
  logic [2:0]  n_max;
  logic [2:0]  n_smp;

  assign prod0 = 36'(item_i.line_index) * 36'(DivMult);
  assign prod1 = (36'(item_i.line_index) + 36'd1) * 36'(DivMult);
  assign quot0 = prod0[DivShift +: 11];
  assign quot1 = prod1[DivShift +: 12];
  // last repeat when index + 1 lands on the next multiple
  assign last_rep = quot1 != {1'b0, quot0};

  assign bottom_blank = ({1'b0, item_i.line_index} + {1'b0, cfg_i.blank_bottom})
                        >= {1'b0, cfg_i.active_lines};

  assign acc_sum = state_i.sample_accum + {8'd0, cfg_i.audio_step};
  assign acc_int = acc_sum[31:16];

  always_comb begin
    if (acc_int > 16'(MAX_SAMPLES)) begin
      n_max = 3'(MAX_SAMPLES);
    end else begin
      n_max = acc_int[2:0];
    end
    if ({7'd0, n_max} > item_i.audio_available) begin
      n_smp = item_i.audio_available[2:0];
    end else begin
      n_smp = n_max;
    end
  end

  always_comb begin
    if (32'(item_i.ready_lines) > QUEUE_DEPTH) begin
      ready_c = 4'(QUEUE_DEPTH);
    end else begin
      ready_c = item_i.ready_lines;
    end
    if (state_i.late_count < {4'd0, ready_c}) begin
      dropped = state_i.late_count[3:0];
    end else begin
      dropped = ready_c;
    end
    ready_left = ready_c - dropped;
    late_after = state_i.late_count - {4'd0, dropped};
  end

  always_comb begin
    result_o = '0;
    state_o  = state_i;
    blank    = 1'b0;
    have     = 1'b0;

    // release pipeline
    result_o.return_shown = state_i.release_older;
    state_o.release_older = state_i.release_newer;
    state_o.release_newer = 1'b0;

    result_o.dropped_lines = dropped;
    state_o.late_count     = late_after;

    case (item_i.line_state)
      LS_ACTIVE: begin
        if (item_i.line_index < cfg_i.blank_top || bottom_blank) begin
          blank = 1'b1;
        end else begin
          if (ready_left != 4'd0) begin
            have = 1'b1;
            if (last_rep) begin
              result_o.pop_shown    = 1'b1;
              state_o.release_newer = 1'b1;
            end
          end else if (last_rep && late_after < 8'(LATE_MAX)) begin
            state_o.late_count = late_after + 8'd1;
          end
          if (cfg_i.scanline_effect && item_i.line_index[0]) begin
            blank = 1'b1;
          end
        end
        if (blank) begin
          result_o.line_kind = LK_BLANK;
        end else if (have) begin
          result_o.line_kind       = LK_ACTIVE;
          result_o.show_from_queue = 1'b1;
        end else begin
          result_o.line_kind = LK_ERROR;
        end
        if (last_rep) begin
          result_o.callback_fire = 1'b1;
          result_o.callback_line = quot0;
        end
      end
      LS_SYNC: begin
        result_o.line_kind = LK_VBLANK_SYNC;
        if (item_i.line_index == 11'd0) begin
          state_o.frame_parity = ~state_i.frame_parity;
        end
      end
      default: begin
        result_o.line_kind = LK_VBLANK;
      end
    endcase

    if (cfg_i.island_enable) begin
      result_o.vsync_level = cfg_i.vsync_polarity == (item_i.line_state == LS_SYNC);
      if (cfg_i.audio_enable) begin
        state_o.sample_accum = acc_sum;
        if (item_i.line_state == LS_FRONT && item_i.line_index == 11'd0) begin
          result_o.packet_kind = state_o.frame_parity ? PK_VIDEO_INFO : PK_AUDIO_INFO;
        end else if (item_i.line_state == LS_FRONT && item_i.line_index == 11'd1) begin
          result_o.packet_kind = PK_CLOCK_REGEN;
        end else begin
          state_o.sample_accum = {acc_int - {13'd0, n_smp}, acc_sum[15:0]};
          if (n_smp != 3'd0) begin
            result_o.packet_kind  = PK_AUDIO;
            result_o.sample_count = n_smp;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/video_scanline_and_island_scheduler_top.sv]
`default_nettype none

// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   line start event
// m_axis    out        m_axis_tvalid / m_axis_tready   line and island decision
// cfg       in         cfg_valid_i / cfg_ready_o       register index, write data
//
// An event passes from acceptance into the input register, then through the
// scheduler logic into the result register.
// A new event is accepted every cycle unless the result is stalled; the result register parts the sides.
// Reset clears the counters, the release pipeline and the sample accumulator.
// A stalled result holds the input register, which then deasserts tready.

module video_scanline_and_island_scheduler_top
  import vsis_pkg::*;
#(
  parameter int unsigned VERTICAL_REPEAT = VERTICAL_REPEAT_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int unsigned MAX_SAMPLES     = MAX_SAMPLES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [10:0] line_index, [14:11] ready_lines, [24:15] audio_available
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] line_state
  input  wire logic [1:0]  s_axis_tuser,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] show_from_queue, [1] pop_shown, [5:2] dropped_lines, [6] return_shown,
  // [7] callback_fire, [18:8] callback_line, [21:19] sample_count,
  // [22] vsync_level
  output logic [23:0]      m_axis_tdata,
  // [2:0] line_kind, [5:3] packet_kind
  output logic [5:0]       m_axis_tuser,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  cfg_t         cfg_q;
  sched_state_t st_q;
  sched_state_t st_d;
  item_t        in_q;
  logic         in_valid_q;
  result_t      res_d;
  result_t      res_q;
  logic         out_valid_q;
  logic         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{active_lines: 11'd480, default: '0};
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BLANK_TOP:       cfg_q.blank_top       <= cfg_data_i[10:0];
        REG_BLANK_BOTTOM:    cfg_q.blank_bottom    <= cfg_data_i[10:0];
        REG_ACTIVE_LINES:    cfg_q.active_lines    <= cfg_data_i[10:0];
        REG_SCANLINE_EFFECT: cfg_q.scanline_effect <= cfg_data_i[0];
        REG_ISLAND_ENABLE:   cfg_q.island_enable   <= cfg_data_i[0];
        REG_AUDIO_ENABLE:    cfg_q.audio_enable    <= cfg_data_i[0];
        REG_AUDIO_STEP:      cfg_q.audio_step      <= cfg_data_i;
        REG_VSYNC_POLARITY:  cfg_q.vsync_polarity  <= cfg_data_i[0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.line_state      <= line_state_e'(s_axis_tuser);
      in_q.line_index      <= s_axis_tdata[10:0];
      in_q.ready_lines     <= s_axis_tdata[14:11];
      in_q.audio_available <= s_axis_tdata[24:15];
    end
  end

  vsis_sched #(
    .VERTICAL_REPEAT (VERTICAL_REPEAT),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .MAX_SAMPLES     (MAX_SAMPLES)
  ) u_sched (
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .item_i   (in_q),
    .result_o (res_d),
    .state_o  (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          res_q.vsync_level,
                          res_q.sample_count,
                          res_q.callback_line,
                          res_q.callback_fire,
                          res_q.return_shown,
                          res_q.dropped_lines,
                          res_q.pop_shown,
                          res_q.show_from_queue};
  assign m_axis_tuser  = {res_q.packet_kind, res_q.line_kind};

endmodule

`default_nettype wire
